// File: rtl/matrix_power_row_normalized_assert.svh
// Assertion macros shared by the matrix power block.
`ifndef MATRIX_POWER_ROW_NORMALIZED_ASSERT_SVH
`define MATRIX_POWER_ROW_NORMALIZED_ASSERT_SVH

// Implication checked on every rising clock edge, masked while reset is low.
`define MPR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is low.
`define MPR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mpr_pkg.sv
// Types, codes and sizing constants of the matrix power block.
package mpr_pkg;

  localparam int unsigned MAX_STATES = 8;
  localparam int unsigned MAX_POWERS = 64;
  localparam int unsigned FRAC_BITS  = 31;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned ROW_W    = 3;
  localparam int unsigned COL_W    = 3;
  localparam int unsigned PIDX_W   = 6;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned SC_W     = 4;
  localparam int unsigned PC_W     = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_STATE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_COUNT = 2'd1;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD    = 2'd0,
    REQ_COMPUTE = 2'd1,
    REQ_READ    = 2'd2,
    REQ_BAD     = 2'd3
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_NOT_READY = 2'd2,
    ST_ZERO_ROW  = 2'd3
  } status_e;

  // divider handshake
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/mpr_if.sv
// Request and response channel interfaces.
interface mpr_req_if;
  logic                         valid;
  logic                         ready;
  logic [mpr_pkg::REQ_W-1:0]    req_type;
  logic [mpr_pkg::ROW_W-1:0]    row;
  logic [mpr_pkg::COL_W-1:0]    col;
  logic [mpr_pkg::PIDX_W-1:0]   power_index;
  logic [mpr_pkg::DATA_W-1:0]   value;
  modport source (output valid, req_type, row, col, power_index, value, input ready);
  modport sink   (input valid, req_type, row, col, power_index, value, output ready);
endinterface

interface mpr_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [mpr_pkg::DATA_W-1:0]   read_value;
  logic [mpr_pkg::STAT_W-1:0]   status;
  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

// File: rtl/mpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mpr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// File: rtl/mpr_div.sv
// Restoring fractional divider: floor(num * 2^FRAC_BITS / den), one bit per cycle.
module mpr_div #(
  parameter int unsigned NUM_W     = 35,
  parameter int unsigned DEN_W     = 38,
  parameter int unsigned FRAC_BITS = mpr_pkg::FRAC_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [NUM_W-1:0]       num_i,
  input  logic [DEN_W-1:0]       den_i,
  output mpr_pkg::div_stat_t     stat_o,
  output logic [FRAC_BITS:0]     quot_o
);
  localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  logic [DEN_W:0]     rem_q, rem_d, trial;
  logic [DEN_W-1:0]   den_q;
  logic [FRAC_BITS:0] q_q, q_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic               ge;

  always_comb begin
    // numerator never exceeds den, so the first step does not shift
    trial  = (cnt_q == '0) ? rem_q : {rem_q[DEN_W-1:0], 1'b0};
    ge     = trial >= {1'b0, den_q};
    rem_d  = rem_q;
    q_d    = q_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = (DEN_W + 1)'(num_i);
      q_d    = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? trial - {1'b0, den_q} : trial;
      q_d   = {q_q[FRAC_BITS-1:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(FRAC_BITS)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    q_q   <= q_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = (q_q > ONE) ? ONE : q_q;
endmodule

// File: rtl/matrix_power_row_normalized.sv
// Load/read: result register (a read first passes S_RD_RESP for the RAM read); ready
// again once the result is taken. Compute: per power and row, a multiply-accumulate in
// S_RD_X, S_RD_Y, S_MUL and S_ACC (one RAM read port shared by both operands) for N*N
// terms, then each entry through the single divider, skipped for a zero-sum row.
// One item at a time. Reset clears control state and flags; the power store holds
// whatever it held, with no clearing pass.
`include "matrix_power_row_normalized_assert.svh"
module matrix_power_row_normalized #(
  parameter int unsigned MAX_STATES = mpr_pkg::MAX_STATES,
  parameter int unsigned MAX_POWERS = mpr_pkg::MAX_POWERS,
  parameter int unsigned FRAC_BITS  = mpr_pkg::FRAC_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mpr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mpr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  mpr_req_if.sink                         req,
  mpr_rsp_if.source                       rsp
);
  localparam int unsigned DW    = mpr_pkg::DATA_W;
  localparam int unsigned SW    = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int unsigned PW    = (MAX_POWERS > 1) ? $clog2(MAX_POWERS) : 1;
  localparam int unsigned AW    = PW + 2 * SW;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam int unsigned NW    = $clog2(MAX_STATES + 1);
  localparam int unsigned PUW   = $clog2(MAX_POWERS + 1);
  localparam int unsigned ACC_W = FRAC_BITS + 1 + SW;
  localparam int unsigned SUM_W = FRAC_BITS + 1 + 2 * SW;
  localparam logic [DW-1:0] ONE = DW'(64'(1) << FRAC_BITS);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_RD_X     = 9'b000000010,
    S_RD_Y     = 9'b000000100,
    S_MUL      = 9'b000001000,
    S_ACC      = 9'b000010000,
    S_DIV_GO   = 9'b000100000,
    S_DIV_WAIT = 9'b001000000,
    S_WR       = 9'b010000000,
    S_RD_RESP  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [mpr_pkg::SC_W-1:0] sc_q;
  logic [mpr_pkg::PC_W-1:0] pc_q;
  logic ready_q, zrow_q, zseen_q;
  logic [SW-1:0] i_q, j_q, k_q;
  logic [PW-1:0] t_q;
  logic [DW-1:0] x_q, qwr_q;
  logic [2*DW-1:0] prod_q;
  logic [ACC_W-1:0] a_q, a_new;
  logic [ACC_W-1:0] acc_q [MAX_STATES];
  logic [SUM_W-1:0] sum_q;
  logic out_valid_q;
  logic [DW-1:0] out_value_q;
  mpr_pkg::status_e out_status_q;

  logic [NW-1:0] n_used;
  logic [PUW-1:0] p_used;
  logic fire, k_last, j_last, i_last, t_last;
  logic in_range, load_ok, read_ok;
  logic [SW-1:0] row_s, col_s;
  logic [PW-1:0] pidx_s;
  logic [DW-1:0] load_val;

  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  logic div_start;
  mpr_pkg::div_stat_t div_stat;
  logic [FRAC_BITS:0] div_quot;

  // clamped dimension and power count
  always_comb begin
    if (sc_q == '0) n_used = NW'(1);
    else if (32'(sc_q) > MAX_STATES) n_used = NW'(MAX_STATES);
    else n_used = NW'(sc_q);
    if (pc_q == '0) p_used = PUW'(1);
    else if (32'(pc_q) > MAX_POWERS) p_used = PUW'(MAX_POWERS);
    else p_used = PUW'(pc_q);
  end

  assign req.ready = (state_q == S_IDLE) && !out_valid_q;
  assign fire      = req.valid && req.ready;

  assign row_s    = SW'(32'(req.row));
  assign col_s    = SW'(32'(req.col));
  assign pidx_s   = PW'(32'(req.power_index));
  assign in_range = (32'(req.row) < 32'(n_used)) && (32'(req.col) < 32'(n_used));
  assign load_ok  = fire && (mpr_pkg::req_e'(req.req_type) == mpr_pkg::REQ_LOAD) && in_range;
  assign read_ok  = in_range && (32'(req.power_index) < 32'(p_used)) && ready_q;
  assign load_val = (req.value > ONE) ? ONE : req.value;

  assign k_last = (32'(k_q) + 1) == 32'(n_used);
  assign j_last = (32'(j_q) + 1) == 32'(n_used);
  assign i_last = (32'(i_q) + 1) == 32'(n_used);
  assign t_last = (32'(t_q) + 1) == 32'(p_used);
  assign a_new  = a_q + ACC_W'(prod_q >> FRAC_BITS);

  // RAM port steering
  always_comb begin
    ram_we    = load_ok || (state_q == S_WR);
    ram_waddr = (state_q == S_WR) ? {t_q, i_q, j_q} : {PW'(0), row_s, col_s};
    ram_wdata = (state_q == S_WR) ? qwr_q : load_val;
    ram_re    = 1'b0;
    ram_raddr = {pidx_s, row_s, col_s};
    case (state_q)
      S_RD_X: begin
        ram_re    = 1'b1;
        ram_raddr = {PW'(0), i_q, k_q};
      end
      S_RD_Y: begin
        ram_re    = 1'b1;
        ram_raddr = {t_q - 1'b1, k_q, j_q};
      end
      default: begin
        ram_re = fire && (mpr_pkg::req_e'(req.req_type) == mpr_pkg::REQ_READ) && read_ok;
      end
    endcase
  end

  assign div_start = (state_q == S_DIV_GO) && (sum_q != '0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (fire) begin
          if (mpr_pkg::req_e'(req.req_type) == mpr_pkg::REQ_COMPUTE && p_used != PUW'(1)) begin
            state_d = S_RD_X;
          end else if (mpr_pkg::req_e'(req.req_type) == mpr_pkg::REQ_READ && read_ok) begin
            state_d = S_RD_RESP;
          end
        end
      end
      S_RD_X:     state_d = S_RD_Y;
      S_RD_Y:     state_d = S_MUL;
      S_MUL:      state_d = S_ACC;
      S_ACC:      state_d = (k_last && j_last) ? S_DIV_GO : S_RD_X;
      S_DIV_GO:   state_d = (sum_q == '0) ? S_WR : S_DIV_WAIT;
      S_DIV_WAIT: state_d = div_stat.done ? S_WR : S_DIV_WAIT;
      S_WR: begin
        if (!j_last) state_d = S_DIV_GO;
        else if (i_last && t_last) state_d = S_IDLE;
        else state_d = S_RD_X;
      end
      S_RD_RESP:  state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sc_q        <= mpr_pkg::SC_W'(2);
      pc_q        <= mpr_pkg::PC_W'(1);
      ready_q     <= 1'b0;
      zrow_q      <= 1'b0;
      zseen_q     <= 1'b0;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      t_q         <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == mpr_pkg::CFG_STATE_COUNT) begin
          sc_q    <= cfg_data_i[mpr_pkg::SC_W-1:0];
          ready_q <= 1'b0;
          zrow_q  <= 1'b0;
        end else if (cfg_idx_i == mpr_pkg::CFG_POWER_COUNT) begin
          pc_q    <= cfg_data_i;
          ready_q <= 1'b0;
          zrow_q  <= 1'b0;
        end
      end
      if (rsp.valid && rsp.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (fire) begin
            if (load_ok) begin
              ready_q <= 1'b0;
              zrow_q  <= 1'b0;
            end
            if (mpr_pkg::req_e'(req.req_type) == mpr_pkg::REQ_COMPUTE) begin
              zseen_q <= 1'b0;
              t_q     <= PW'(1);
              i_q     <= '0;
              j_q     <= '0;
              k_q     <= '0;
              if (p_used == PUW'(1)) begin
                ready_q     <= 1'b1;
                zrow_q      <= 1'b0;
                out_valid_q <= 1'b1;
              end
            end else if (!(mpr_pkg::req_e'(req.req_type) == mpr_pkg::REQ_READ && read_ok)) begin
              out_valid_q <= 1'b1;
            end
          end
        end
        S_ACC: begin
          if (k_last) begin
            k_q <= '0;
            j_q <= j_last ? '0 : j_q + 1'b1;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        S_DIV_GO: begin
          if (sum_q == '0) zseen_q <= 1'b1;
        end
        S_WR: begin
          if (!j_last) begin
            j_q <= j_q + 1'b1;
          end else begin
            j_q <= '0;
            if (i_last) begin
              i_q <= '0;
              if (t_last) begin
                ready_q     <= 1'b1;
                zrow_q      <= zseen_q;
                out_valid_q <= 1'b1;
              end else begin
                t_q <= t_q + 1'b1;
              end
            end else begin
              i_q <= i_q + 1'b1;
            end
          end
        end
        S_RD_RESP: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        a_q   <= '0;
        sum_q <= '0;
        if (fire) begin
          out_value_q <= '0;
          case (mpr_pkg::req_e'(req.req_type))
            mpr_pkg::REQ_LOAD:
              out_status_q <= in_range ? mpr_pkg::ST_OK : mpr_pkg::ST_RANGE;
            mpr_pkg::REQ_COMPUTE:  out_status_q <= mpr_pkg::ST_OK;
            mpr_pkg::REQ_READ: begin
              if (!(in_range && (32'(req.power_index) < 32'(p_used))))
                out_status_q <= mpr_pkg::ST_RANGE;
              else if (!ready_q) out_status_q <= mpr_pkg::ST_NOT_READY;
              else out_status_q <= zrow_q ? mpr_pkg::ST_ZERO_ROW : mpr_pkg::ST_OK;
            end
            default: out_status_q <= mpr_pkg::ST_RANGE;
          endcase
        end
      end
      S_RD_Y: x_q <= ram_rdata;
      S_MUL:  prod_q <= x_q * ram_rdata;
      S_ACC: begin
        if (k_last) begin
          acc_q[j_q] <= a_new;
          sum_q      <= sum_q + SUM_W'(a_new);
          a_q        <= '0;
        end else begin
          a_q <= a_new;
        end
      end
      S_DIV_GO: qwr_q <= '0;
      S_DIV_WAIT: begin
        if (div_stat.done) qwr_q <= DW'(div_quot);
      end
      S_WR: begin
        if (j_last) sum_q <= '0;
        if (j_last && i_last && t_last) begin
          out_value_q  <= '0;
          out_status_q <= zseen_q ? mpr_pkg::ST_ZERO_ROW : mpr_pkg::ST_OK;
        end
      end
      S_RD_RESP: out_value_q <= ram_rdata;
      default: ;
    endcase
  end

  assign rsp.valid      = out_valid_q;
  assign rsp.read_value = out_value_q;
  assign rsp.status     = out_status_q;

  mpr_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mpr_div #(
    .NUM_W     (ACC_W),
    .DEN_W     (SUM_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_q[j_q]),
    .den_i   (sum_q),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  `MPR_ASSERT_IMP(a_ready_no_pending, req.ready, !rsp.valid, "ready while result pending")
  `MPR_ASSERT_IMP(a_div_done_state, div_stat.done, state_q == S_DIV_WAIT, "stray divider done")
  `MPR_ASSERT_IMP(a_ram_we_state, ram_we, state_q == S_WR || state_q == S_IDLE, "stray store write")
  `MPR_ASSERT_NXT(a_div_start_busy, div_start, div_stat.busy, "divider did not start")
endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for matrix_power_row_normalized: directed and randomized requests.
module tb;
  import mpr_pkg::*;

  localparam longint unsigned ONE_Q = 64'd1 << FRAC_BITS;
  localparam int unsigned CYCLE_LIMIT = 6000000;

  // Predictor of the power store and flags, plus the queue of expected responses
  class power_tracker;
    bit [DATA_W-1:0] store [MAX_POWERS][MAX_STATES][MAX_STATES];
    bit              ready_flag;
    bit              zero_flag;
    int unsigned     n_states;
    int unsigned     n_powers;
    bit [DATA_W-1:0] exp_value [$];
    status_e         exp_status [$];
    int unsigned     errors;
    int unsigned     computes;
    int unsigned     zero_computes;
    int unsigned     checked;

    function new();
      n_states = 2;
      n_powers = 1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      int unsigned v;
      if (idx == CFG_STATE_COUNT) begin
        v = d[SC_W-1:0];
        n_states = (v < 1) ? 1 : (v > MAX_STATES) ? MAX_STATES : v;
      end else if (idx == CFG_POWER_COUNT) begin
        v = d;
        n_powers = (v < 1) ? 1 : (v > MAX_POWERS) ? MAX_POWERS : v;
      end else begin
        return;
      end
      ready_flag = 0;
      zero_flag = 0;
    endfunction

    // floor(num * ONE / den), restoring division, saturated at ONE
    function bit [63:0] ratio(bit [63:0] num, bit [63:0] den);
      bit [63:0] q;
      bit [63:0] rem;
      q = 0;
      rem = num;
      if (rem >= den) begin
        q = 1;
        rem -= den;
      end
      for (int b = 0; b < FRAC_BITS; b++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= den) begin
          rem -= den;
          q[0] = 1'b1;
        end
      end
      return (q > ONE_Q) ? ONE_Q : q;
    endfunction

    function bit run_powers();
      bit [63:0] acc [MAX_STATES];
      bit [63:0] sum;
      bit [63:0] a;
      bit        zero;
      zero = 0;
      for (int t = 1; t < n_powers; t++) begin
        for (int i = 0; i < n_states; i++) begin
          sum = 0;
          for (int j = 0; j < n_states; j++) begin
            a = 0;
            for (int k = 0; k < n_states; k++)
              a += (64'(store[0][i][k]) * 64'(store[t-1][k][j])) >> FRAC_BITS;
            acc[j] = a;
            sum += a;
          end
          for (int j = 0; j < n_states; j++)
            store[t][i][j] = (sum != 0) ? DATA_W'(ratio(acc[j], sum)) : '0;
          if (sum == 0) zero = 1;
        end
      end
      return zero;
    endfunction

    function void note_request(req_e r, bit [ROW_W-1:0] row, bit [COL_W-1:0] col,
                               bit [PIDX_W-1:0] pidx, bit [DATA_W-1:0] val);
      bit [DATA_W-1:0] rv;
      status_e         st;
      rv = 0;
      st = ST_OK;
      case (r)
        REQ_LOAD: begin
          if (row >= n_states || col >= n_states) begin
            st = ST_RANGE;
          end else begin
            store[0][row][col] = (val > ONE_Q) ? DATA_W'(ONE_Q) : val;
            ready_flag = 0;
            zero_flag = 0;
          end
        end
        REQ_COMPUTE: begin
          zero_flag = run_powers();
          ready_flag = 1;
          st = zero_flag ? ST_ZERO_ROW : ST_OK;
          computes++;
          if (zero_flag) zero_computes++;
        end
        REQ_READ: begin
          if (row >= n_states || col >= n_states || pidx >= n_powers) st = ST_RANGE;
          else if (!ready_flag) st = ST_NOT_READY;
          else begin
            rv = store[pidx][row][col];
            st = zero_flag ? ST_ZERO_ROW : ST_OK;
          end
        end
        default: st = ST_RANGE;
      endcase
      exp_value.push_back(rv);
      exp_status.push_back(st);
    endfunction

    function void check_response(bit [DATA_W-1:0] rv, status_e st);
      bit [DATA_W-1:0] ev;
      status_e         es;
      if (exp_value.size() == 0) begin
        $error("response with nothing outstanding: read_value %h status %s", rv, st.name());
        errors++;
        return;
      end
      ev = exp_value.pop_front();
      es = exp_status.pop_front();
      checked++;
      if (rv !== ev) begin
        $error("read_value mismatch: expected %h actual %h", ev, rv);
        errors++;
      end
      if (st !== es) begin
        $error("status mismatch: expected %s actual %s", es.name(), st.name());
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  mpr_req_if req ();
  mpr_rsp_if rsp ();

  matrix_power_row_normalized dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req       (req.sink),
    .rsp       (rsp.source)
  );

  power_tracker tracker = new();
  bit           calm;
  bit           hold_req;
  int unsigned  cycles;
  int unsigned  sent;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("matrix_power_row_normalized regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && rsp.valid && rsp.ready)
      tracker.check_response(rsp.read_value, status_e'(rsp.status));

  // response side: random stall bursts, one long hold-off on request
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        rsp.ready <= 1'b0;
        repeat (299) @(negedge clk_i);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk_i);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send(req_e r, bit [ROW_W-1:0] row, bit [COL_W-1:0] col,
                      bit [PIDX_W-1:0] pidx, bit [DATA_W-1:0] val);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    req.valid       <= 1'b1;
    req.req_type    <= r;
    req.row         <= row;
    req.col         <= col;
    req.power_index <= pidx;
    req.value       <= val;
    do @(posedge clk_i); while (!req.ready);
    tracker.note_request(r, row, col, pidx, val);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (tracker.exp_value.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_regs(logic [CFG_DATA_W-1:0] sc, logic [CFG_DATA_W-1:0] pc);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_STATE_COUNT;
    cfg_data_i <= sc;
    @(posedge clk_i);
    tracker.write_reg(CFG_STATE_COUNT, sc);
    @(negedge clk_i);
    cfg_idx_i  <= CFG_POWER_COUNT;
    cfg_data_i <= pc;
    @(posedge clk_i);
    tracker.write_reg(CFG_POWER_COUNT, pc);
    @(negedge clk_i);
    // index past the register list: no effect
    cfg_idx_i  <= CFG_IDX_W'($urandom_range(2, 3));
    cfg_data_i <= CFG_DATA_W'($urandom);
    @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic bit [DATA_W-1:0] rand_entry();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DATA_W'(ONE_Q);
      2:       return $urandom | 32'h8000_0001;
      default: return $urandom_range(0, 32'h8000_0000);
    endcase
  endfunction

  task automatic rand_item();
    int unsigned n;
    int unsigned p;
    int unsigned pick;
    bit [ROW_W-1:0]  row;
    bit [COL_W-1:0]  col;
    bit [PIDX_W-1:0] pidx;
    n = tracker.n_states;
    p = tracker.n_powers;
    pick = $urandom_range(0, 99);
    row  = ($urandom_range(0, 6) != 0) ? ROW_W'($urandom_range(0, n - 1)) : ROW_W'($urandom);
    col  = ($urandom_range(0, 6) != 0) ? COL_W'($urandom_range(0, n - 1)) : COL_W'($urandom);
    pidx = ($urandom_range(0, 6) != 0) ? PIDX_W'($urandom_range(0, p - 1)) : PIDX_W'($urandom);
    if (pick < 2) send(REQ_COMPUTE, ROW_W'($urandom), COL_W'($urandom), PIDX_W'($urandom),
                       $urandom);
    else if (pick < 6) send(REQ_BAD, row, col, pidx, $urandom);
    else if (pick < 20) send(REQ_LOAD, row, col, pidx, rand_entry());
    else send(REQ_READ, row, col, pidx, $urandom);
  endtask

  initial begin
    int unsigned zrow;
    int unsigned body;
    logic [CFG_DATA_W-1:0] sc;
    logic [CFG_DATA_W-1:0] pc;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_STATE_COUNT;
    cfg_data_i      = '0;
    req.valid       = 1'b0;
    req.req_type    = REQ_LOAD;
    req.row         = '0;
    req.col         = '0;
    req.power_index = '0;
    req.value       = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: defaults N=2, P=1
    send(REQ_READ, 0, 0, 0, 0);
    send(REQ_BAD, 7, 7, 63, 32'hFFFF_FFFF);
    send(REQ_LOAD, 2, 0, 0, 32'h1234_5678);
    send(REQ_LOAD, 0, 7, 0, 32'h1234_5678);
    send(REQ_LOAD, 0, 0, 0, 32'h8000_0000);
    send(REQ_LOAD, 0, 1, 0, 32'hFFFF_FFFF);
    send(REQ_LOAD, 1, 0, 0, 32'h0);
    send(REQ_LOAD, 1, 1, 0, 32'h0);
    send(REQ_READ, 0, 1, 0, 0);
    send(REQ_COMPUTE, 0, 0, 0, 0);
    send(REQ_READ, 0, 1, 0, 0);
    send(REQ_READ, 0, 1, 1, 0);
    drain();
    write_regs(2, 3);
    send(REQ_READ, 0, 0, 0, 0);
    send(REQ_COMPUTE, 0, 0, 0, 0);
    send(REQ_READ, 1, 1, 2, 0);
    send(REQ_READ, 0, 0, 2, 0);
    send(REQ_READ, 0, 0, 3, 0);
    send(REQ_LOAD, 1, 0, 0, 32'h7FFF_FFFF);
    send(REQ_COMPUTE, 0, 0, 0, 0);
    send(REQ_READ, 1, 0, 1, 0);
    send(REQ_READ, 0, 1, 2, 0);

    for (int ph = 0; ph < 22; ph++) begin
      if (ph >= 19) calm = 1;
      drain();
      if (ph == 0) begin
        sc = 15;
        pc = 127;
      end else if (ph == 1) begin
        sc = 0;
        pc = 0;
      end else begin
        sc = $urandom_range(0, 15);
        pc = (sc > 4 && sc != 0) ? $urandom_range(0, 6) : $urandom_range(0, 16);
        if (sc inside {[1:2]} && $urandom_range(0, 3) == 0) pc = $urandom_range(65, 127);
      end
      write_regs(sc, pc);
      zrow = ($urandom_range(0, 3) == 0) ? $urandom_range(0, tracker.n_states - 1) : 99;
      if (ph == 3) hold_req = 1;
      for (int i = 0; i < tracker.n_states; i++)
        for (int j = 0; j < tracker.n_states; j++)
          send(REQ_LOAD, i, j, PIDX_W'($urandom), (i == zrow) ? '0 : rand_entry());
      send(REQ_COMPUTE, 0, 0, 0, 0);
      body = (ph == 0) ? 20 : 67 - tracker.n_states * tracker.n_states / 2;
      for (int k = 0; k < body; k++) begin
        if (ph == 5 && k == body / 2) drain();
        rand_item();
      end
    end

    req.valid <= 1'b0;
    while (tracker.exp_value.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    $display("covered %0d requests, %0d responses checked", sent, tracker.checked);
    $display("%0d power computations, %0d of them hit a zero-sum row",
             tracker.computes, tracker.zero_computes);
    if (tracker.errors == 0 && tracker.exp_value.size() == 0)
      $display("matrix_power_row_normalized regression: pass");
    else
      $display("matrix_power_row_normalized regression: fail");
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl
rtl/mpr_pkg.sv
rtl/mpr_if.sv
rtl/mpr_ram.sv
rtl/mpr_div.sv
rtl/matrix_power_row_normalized.sv
tb/sv/tb.sv
